// ----- rtl/imusr_pkg.sv -----
// shared constants and types for the imu sample ring with impact detect
`default_nettype none

package imusr_pkg;

    localparam int RING_DEPTH = 32;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int FILL_W     = 6;
    localparam int FIELD_W    = 16;
    localparam int SAMPLE_W   = 7 * FIELD_W;
    localparam int SQ_W       = 31;
    localparam int MAG_W      = 32;
    localparam int OUT_DATA_W = 120;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0] OP_PUSH  = 1'b0;
    localparam logic [0:0] OP_DRAIN = 1'b1;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [0:0] REG_THRESHOLD   = 1'b0;
    localparam logic [15:0] THRESHOLD_RESET = 16'd16384;

    typedef struct packed {
        logic signed [FIELD_W-1:0] temperature;
        logic signed [FIELD_W-1:0] gyro_z;
        logic signed [FIELD_W-1:0] gyro_y;
        logic signed [FIELD_W-1:0] gyro_x;
        logic signed [FIELD_W-1:0] accel_z;
        logic signed [FIELD_W-1:0] accel_y;
        logic signed [FIELD_W-1:0] accel_x;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_EMPTY = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/imu_sample_ring_with_impact_detect_unit.sv -----
// top level: sample ring in one memory, impact check, drain sequencer
//
//  channel  ports              word
//  -------  -----------------  -----------------------------------------------
//  input    s_tvalid/s_tready  s_tuser opcode, s_tdata seven sample fields
//  result   m_tvalid/m_tready  m_tuser kind, m_tdata sample/impact/fill, m_tlast
//  config   psel/penable/...   impact_threshold at byte address 0
//
// a push first writes memory and registers the squares, then sums, compares and registers the result
// a drain of n samples does one memory read per sample, paced by m_tready
// input is taken only in idle; the result register lets the next word in while it waits
// reset clears the oldest pointer, count, impact flag and threshold; the sample memory is not cleared
`default_nettype none

module imu_sample_ring_with_impact_detect_unit
    import imusr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [SAMPLE_W-1:0]     s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temperature
    input  wire logic [0:0]              s_tuser,   // opcode

    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_DATA_W-1:0]        m_tdata,   // out_accel_x .. out_temperature, impact, fill_level, pad
    output logic [1:0]                   m_tuser,   // kind
    output logic                         m_tlast,

    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    sample_t               mem [RING_DEPTH];
    sample_t               rdata_reg;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      oldest_reg, oldest_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic                  impact_reg, impact_next;
    logic [15:0]           thr_reg;

    logic [SQ_W-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [MAG_W-1:0]      thr2_reg;

    logic                  out_valid_reg, out_valid_next;
    sample_t               out_data_reg, out_data_next;
    logic [1:0]            out_kind_reg, out_kind_next;
    logic                  out_impact_reg, out_impact_next;
    logic [FILL_W-1:0]     out_fill_reg, out_fill_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_accept;
    logic                  is_push;
    logic                  out_free;
    logic                  cfg_write;
    logic [SUM_W-1:0]      slot_sum;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      oldest_inc;
    logic [IDX_W-1:0]      ptr_inc;
    logic [MAG_W-1:0]      mag2;
    logic                  hit;
    sample_t               in_sample;
    logic signed [2*FIELD_W-1:0] px, py, pz;

    assign in_sample = sample_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign is_push   = (s_tuser == OP_PUSH);
    assign out_free  = !out_valid_reg || m_tready;

    // ring position arithmetic
    assign slot_sum   = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign slot       = (slot_sum >= SUM_W'(RING_DEPTH)) ?
                        IDX_W'(slot_sum - SUM_W'(RING_DEPTH)) : IDX_W'(slot_sum);
    assign oldest_inc = (oldest_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign ptr_inc    = (ptr_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    assign px = in_sample.accel_x * in_sample.accel_x;
    assign py = in_sample.accel_y * in_sample.accel_y;
    assign pz = in_sample.accel_z * in_sample.accel_z;

    assign mag2 = MAG_W'(sqx_reg) + MAG_W'(sqy_reg) + MAG_W'(sqz_reg);
    assign hit  = mag2 > thr2_reg;

    always_comb begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        ptr_next        = ptr_reg;
        impact_next     = impact_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_kind_next   = out_kind_reg;
        out_impact_next = out_impact_reg;
        out_fill_next   = out_fill_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (is_push) begin
                        if (count_reg == CNT_W'(RING_DEPTH)) begin
                            oldest_next = oldest_inc;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_CHECK;
                    end else begin
                        ptr_next    = oldest_reg;
                        remain_next = count_reg;
                        oldest_next = '0;
                        count_next  = '0;
                        state_next  = (count_reg == '0) ? ST_EMPTY : ST_DRAIN;
                    end
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    impact_next     = impact_reg || hit;
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_kind_next   = KIND_ACK;
                    out_impact_next = impact_reg || hit;
                    out_fill_next   = FILL_W'(count_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_kind_next   = KIND_EMPTY;
                    out_impact_next = impact_reg;
                    out_fill_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rdata_reg;
                    out_kind_next   = KIND_SAMPLE;
                    out_impact_next = impact_reg;
                    out_fill_next   = '0;
                    out_last_next   = (remain_reg == CNT_W'(1));
                    remain_next     = remain_reg - 1'b1;
                    ptr_next        = ptr_inc;
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sample memory, read address runs one step ahead of the drain pointer
    always_ff @(posedge aclk) begin
        if (in_accept && is_push) begin
            mem[slot] <= in_sample;
        end
        rdata_reg <= mem[ptr_next];
    end

    always_ff @(posedge aclk) begin
        if (in_accept && is_push) begin
            sqx_reg  <= px[SQ_W-1:0];
            sqy_reg  <= py[SQ_W-1:0];
            sqz_reg  <= pz[SQ_W-1:0];
            thr2_reg <= MAG_W'(thr_reg) * MAG_W'(thr_reg);
        end
        out_data_reg   <= out_data_next;
        out_kind_reg   <= out_kind_next;
        out_impact_reg <= out_impact_next;
        out_fill_reg   <= out_fill_next;
        out_last_reg   <= out_last_next;
        remain_reg     <= remain_next;
        ptr_reg        <= ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            impact_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            impact_reg    <= impact_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else if (cfg_write && (paddr[2] == REG_THRESHOLD)) begin
            thr_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, thr_reg} : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_fill_reg, out_impact_reg, SAMPLE_W'(out_data_reg)};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- bench/imu_sample_ring_with_impact_detect_unit_tb.sv -----
// testbench for the imu sample ring: directed and random push/drain traffic checked word by word
`default_nettype none

module imu_sample_ring_with_impact_detect_unit_tb;
    import imusr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_SPARE = 1;   // first index past the register list

    typedef struct {
        logic [1:0]        kind;
        sample_t           data;
        logic              impact;
        logic [FILL_W-1:0] fill;
        logic              last;
    } ring_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic [0:0]            s_tuser = OP_PUSH;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // copy of the ring state
    sample_t           ring_store [RING_DEPTH];
    int unsigned       ring_head = 0;
    int unsigned       ring_count = 0;
    logic              impact_flag = 1'b0;
    logic [15:0]       threshold_reg = THRESHOLD_RESET;
    ring_word_t        results_due [$];

    int                fail_count = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                hold_request = 0;
    int                hold_left = 0;
    string             field_names [7] = '{"accel_x", "accel_y", "accel_z",
                                           "gyro_x", "gyro_y", "gyro_z", "temperature"};

    imu_sample_ring_with_impact_detect_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temperature
        .s_tuser  (s_tuser),    // opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_accel_x .. out_temperature, impact, fill_level, pad
        .m_tuser  (m_tuser),    // kind
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input int idx);
        return APB_ADDR_W'(4 * idx);
    endfunction

    function automatic sample_t mk_sample(input int ax, input int ay, input int az,
                                          input int gx, input int gy, input int gz,
                                          input int t);
        sample_t s;
        s.accel_x     = 16'(ax);
        s.accel_y     = 16'(ay);
        s.accel_z     = 16'(az);
        s.gyro_x      = 16'(gx);
        s.gyro_y      = 16'(gy);
        s.gyro_z      = 16'(gz);
        s.temperature = 16'(t);
        return s;
    endfunction

    function automatic sample_t random_sample();
        logic [SAMPLE_W-1:0] v;
        for (int j = 0; j < 7; j++) begin
            v[16*j +: 16] = 16'($urandom_range(65535));
        end
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    // apply one accepted word to the ring copy and queue the words it yields
    task automatic ring_copy_apply(input logic [0:0] op, input sample_t smp);
        ring_word_t  w;
        int unsigned slot;
        int unsigned n;
        longint      ax, ay, az, mag2, lim2;
        if (op == OP_PUSH) begin
            slot = (ring_head + ring_count) % RING_DEPTH;
            ring_store[slot] = smp;
            if (ring_count < RING_DEPTH) begin
                ring_count++;
            end else begin
                ring_head = (ring_head + 1) % RING_DEPTH;
            end
            ax = $signed(smp.accel_x);
            ay = $signed(smp.accel_y);
            az = $signed(smp.accel_z);
            mag2 = ax * ax + ay * ay + az * az;
            lim2 = longint'(threshold_reg) * longint'(threshold_reg);
            if (mag2 > lim2) begin
                impact_flag = 1'b1;
            end
            w.kind   = KIND_ACK;
            w.data   = '0;
            w.impact = impact_flag;
            w.fill   = FILL_W'(ring_count);
            w.last   = 1'b1;
            results_due.push_back(w);
        end else begin
            n = ring_count;
            if (n == 0) begin
                w.kind   = KIND_EMPTY;
                w.data   = '0;
                w.impact = impact_flag;
                w.fill   = '0;
                w.last   = 1'b1;
                results_due.push_back(w);
            end
            for (int unsigned i = 0; i < n; i++) begin
                w.kind   = KIND_SAMPLE;
                w.data   = ring_store[(ring_head + i) % RING_DEPTH];
                w.impact = impact_flag;
                w.fill   = '0;
                w.last   = (i + 1 == n);
                results_due.push_back(w);
            end
            ring_head  = 0;
            ring_count = 0;
        end
    endtask

    task automatic send_word(input logic [0:0] op, input sample_t smp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 60) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        ring_copy_apply(op, smp);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [15:0] value);
        logic [31:0] rd;
        apb_access(1'b1, reg_addr(REG_THRESHOLD), 32'(value), rd);
        threshold_reg = value;
        apb_access(1'b0, reg_addr(REG_THRESHOLD), '0, rd);
        compare_field("impact_threshold", 32'(threshold_reg), 32'(rd[15:0]));
    endtask

    // receiver side: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : watch_results
        ring_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected word: kind %0d tdata %0h", m_tuser, m_tdata);
                end
            end else begin
                w = results_due.pop_front();
                compare_field("kind", 32'(w.kind), 32'(m_tuser));
                for (int j = 0; j < 7; j++) begin
                    compare_field(field_names[j], 32'(w.data[16*j +: 16]),
                                  32'(m_tdata[16*j +: 16]));
                end
                compare_field("impact", 32'(w.impact), 32'(m_tdata[SAMPLE_W]));
                compare_field("fill_level", 32'(w.fill), 32'(m_tdata[SAMPLE_W+1 +: FILL_W]));
                compare_field("last", 32'(w.last), 32'(m_tlast));
            end
        end
    end

    task automatic test_reset_state();
        logic [31:0] rd;
        apb_access(1'b0, reg_addr(REG_THRESHOLD), '0, rd);
        compare_field("impact_threshold", 32'(THRESHOLD_RESET), 32'(rd[15:0]));
        send_word(OP_DRAIN, random_sample());
        // magnitude exactly at the limit does not trip
        send_word(OP_PUSH, mk_sample(16384, 0, 0, 1, 2, 3, 4));
        send_word(OP_PUSH, mk_sample(0, -16384, 0, -1, -2, -3, -4));
        send_word(OP_DRAIN, random_sample());
        send_word(OP_DRAIN, random_sample());
        wait_drained();
    endtask

    task automatic test_field_extremes();
        logic [31:0] rd;
        set_threshold(16'hFFFF);
        // write past the register list must leave the threshold alone
        apb_access(1'b1, reg_addr(REG_SPARE), '0, rd);
        apb_access(1'b0, reg_addr(REG_THRESHOLD), '0, rd);
        compare_field("impact_threshold", 32'(threshold_reg), 32'(rd[15:0]));
        send_word(OP_PUSH, mk_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_word(OP_PUSH, mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_word(OP_PUSH, mk_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                     16'hAAAA, 16'h5555));
        send_word(OP_PUSH, mk_sample(0, 0, 0, 0, 0, 0, 0));
        send_word(OP_PUSH, mk_sample(-1, 1, -32768, 32767, -1, 0, 1));
        send_word(OP_DRAIN, mk_sample(-1, -1, -1, -1, -1, -1, -1));
        wait_drained();
    endtask

    task automatic test_ring_wrap();
        set_threshold(16'd60000);
        idle_pct  = 0;
        stall_pct = 0;
        repeat (RING_DEPTH + 8) send_word(OP_PUSH, random_sample());
        send_word(OP_DRAIN, random_sample());
        send_word(OP_DRAIN, random_sample());
        wait_drained();
    endtask

    task automatic run_traffic(input int idle, input int stall, input int n_words);
        int sent;
        int k;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 75) begin
                k = ($urandom_range(7) == 0) ? $urandom_range(RING_DEPTH + 1, RING_DEPTH + 8)
                                             : $urandom_range(1, 8);
                repeat (k) send_word(OP_PUSH, random_sample());
                send_word(OP_DRAIN, random_sample());
                sent += k + 1;
            end else begin
                send_word(1'($urandom_range(1)), random_sample());
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_zero_threshold();
        set_threshold(16'd0);
        idle_pct  = 0;
        stall_pct = 0;
        // no acceleration at all does not trip even a zero limit
        send_word(OP_PUSH, mk_sample(0, 0, 0, -32768, 32767, 12345, -500));
        send_word(OP_DRAIN, random_sample());
        wait_drained();
    endtask

    task automatic test_threshold_boundary();
        set_threshold(16'd1000);
        send_word(OP_PUSH, mk_sample(1000, 0, 0, 7, 7, 7, 7));
        send_word(OP_PUSH, mk_sample(-600, -800, 0, 8, 8, 8, 8));
        send_word(OP_PUSH, mk_sample(600, -800, 1, 9, 9, 9, 9));
        // sticky from here on
        send_word(OP_PUSH, mk_sample(0, 0, 0, 0, 0, 0, 0));
        send_word(OP_DRAIN, random_sample());
        send_word(OP_DRAIN, random_sample());
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_request = 300;
        repeat (RING_DEPTH + 8) send_word(OP_PUSH, random_sample());
        send_word(OP_DRAIN, random_sample());
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_field_extremes();
        test_ring_wrap();
        set_threshold(16'hFFFF);
        run_traffic(0, 0, 35);
        set_threshold(16'd60000);
        run_traffic(83, 0, 35);
        set_threshold(16'd56756);
        run_traffic(0, 83, 35);
        test_zero_threshold();
        test_threshold_boundary();
        set_threshold(16'd16384);
        run_traffic(23, 23, 35);
        set_threshold(16'hFFFF);
        test_backpressure();

        wait_drained();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/imusr_pkg.sv
rtl/imu_sample_ring_with_impact_detect_unit.sv
bench/imu_sample_ring_with_impact_detect_unit_tb.sv
